### hw/rtl/surface_of_revolution_strip_unit_defines.svh
// Assertion macros for the surface-of-revolution strip unit
`ifndef SURFACE_OF_REVOLUTION_STRIP_UNIT_DEFINES_SVH
`define SURFACE_OF_REVOLUTION_STRIP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SORS_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("strip unit check failed");
`define SORS_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("strip unit reset check failed");
`else
`define SORS_CHECK(lbl, prop)
`define SORS_CHECK_RST(lbl, prop)
`endif
`endif

### hw/rtl/sorstrip_pkg.sv
// Types, codes and trig table for the surface-of-revolution strip unit
package sorstrip_pkg;

  localparam logic [2:0] CFG_ANGLE_STEPS   = 3'd0;
  localparam logic [2:0] CFG_SEGMENT_COUNT = 3'd1;
  localparam logic [2:0] CFG_TEX_MODE      = 3'd2;
  localparam logic [2:0] CFG_SCALE_U       = 3'd3;
  localparam logic [2:0] CFG_SCALE_V       = 3'd4;

  localparam logic [1:0] TEX_WRAP     = 2'd0;
  localparam logic [1:0] TEX_SIDE     = 2'd1;
  localparam logic [1:0] TEX_TOP      = 2'd2;
  localparam logic [1:0] TEX_ONESIDED = 2'd3;

  localparam int NUM_W = 26;
  localparam int DEN_W = 16;
  localparam logic signed [27:0] HALF_Q88      = 28'sd128;
  localparam logic signed [15:0] MINUS_ONE_Q88 = -16'sd256;

  localparam real TWO_PI = 2.0 * 3.14159265358979323846;
  localparam real ANGLE_STEP [32] = '{
    0.0,           TWO_PI / 1.0,  TWO_PI / 2.0,  TWO_PI / 3.0,
    TWO_PI / 4.0,  TWO_PI / 5.0,  TWO_PI / 6.0,  TWO_PI / 7.0,
    TWO_PI / 8.0,  TWO_PI / 9.0,  TWO_PI / 10.0, TWO_PI / 11.0,
    TWO_PI / 12.0, TWO_PI / 13.0, TWO_PI / 14.0, TWO_PI / 15.0,
    TWO_PI / 16.0, TWO_PI / 17.0, TWO_PI / 18.0, TWO_PI / 19.0,
    TWO_PI / 20.0, TWO_PI / 21.0, TWO_PI / 22.0, TWO_PI / 23.0,
    TWO_PI / 24.0, TWO_PI / 25.0, TWO_PI / 26.0, TWO_PI / 27.0,
    TWO_PI / 28.0, TWO_PI / 29.0, TWO_PI / 30.0, TWO_PI / 31.0
  };

  typedef struct packed {
    logic signed [15:0] radius_near;
    logic signed [15:0] height_near;
    logic signed [15:0] radius_far;
    logic signed [15:0] height_far;
    logic [9:0]         segment_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic               last;
    logic               u_neg;
    logic               u_half;
    logic               u_force;
  } vtx_tag_t;

  typedef struct packed {
    logic v_neg;
    logic v_half;
  } v_tag_t;

  typedef logic [31:0] trig_rom_t [1024];

  function automatic logic [15:0] round_q14(real v);
    int r;
    if (v >= 0.0) r = $rtoi(v + 0.5);
    else r = -$rtoi(0.5 - v);
    return 16'(r);
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t t;
    real a;
    for (int n = 0; n < 32; n++) begin
      for (int i = 0; i < 32; i++) begin
        if (n == 0 || i >= n) begin
          t[n * 32 + i] = 32'd0;
        end else begin
          a = ANGLE_STEP[n] * i;
          t[n * 32 + i] = {round_q14($cos(a) * 16384.0), round_q14($sin(a) * 16384.0)};
        end
      end
    end
    return t;
  endfunction

endpackage

### hw/rtl/sorstrip_div.sv
// Pipelined restoring divider, one quotient bit per stage
module sorstrip_div #(
  parameter int W  = 26,
  parameter int DW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [W-1:0]  quo,
  output logic [TW-1:0] tag_out
);

  logic [DW-1:0] rem [W];
  logic [W-1:0]  nq  [W];
  logic [TW-1:0] tg  [W];
  logic          vl  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [DW-1:0] rem_prev;
    logic [W-1:0]  nq_prev;
    logic [TW-1:0] tg_prev;
    logic          vl_prev;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign nq_prev  = num;
      assign tg_prev  = tag_in;
      assign vl_prev  = in_valid;
    end else begin : g_rest
      assign rem_prev = rem[k-1];
      assign nq_prev  = nq[k-1];
      assign tg_prev  = tg[k-1];
      assign vl_prev  = vl[k-1];
    end

    assign trial = {rem_prev, nq_prev[W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= vl_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
        nq[k]  <= {nq_prev[W-2:0], ge};
        tg[k]  <= tg_prev;
      end
    end
  end

  assign out_valid = vl[W-1];
  assign quo       = nq[W-1];
  assign tag_out   = tg[W-1];

endmodule

### hw/rtl/surface_of_revolution_strip_unit.sv
// Top level of the surface-of-revolution strip unit
// Usage:
// - Write registers through cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while the unit is idle.
// - Each item on in_valid/in_ready is one profile segment. It yields
//   2*(n+1) vertices on out_valid/out_ready, n being angle_steps (0 taken
//   as 1), near vertex first, last set on the final far vertex.
// - Throughput: one vertex per cycle while out_ready does not stall
//   the pipeline. The next segment is taken in the cycle the previous
//   one issues its final vertex.
// - Path: after the item is taken, the first vertex passes the
//   sequencer, trig table read, multiply, round, a 26-stage divider
//   for each texture coordinate and the output register.
// - Reset (rst, synchronous) empties the pipeline and loads register
//   defaults: 8 steps, 1 segment, wrap mode, both scales 1.0.
// - When the receiver stalls, the whole pipeline holds; nothing is lost.
`include "surface_of_revolution_strip_unit_defines.svh"
module surface_of_revolution_strip_unit #(
  parameter int MAX_STEPS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sorstrip_pkg::in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sorstrip_pkg::out_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int NW = sorstrip_pkg::NUM_W;
  localparam int DW = sorstrip_pkg::DEN_W;
  localparam int TAGW = $bits(sorstrip_pkg::vtx_tag_t);
  localparam int VTW  = $bits(sorstrip_pkg::v_tag_t);
  localparam sorstrip_pkg::trig_rom_t TRIG_ROM = sorstrip_pkg::build_trig_rom();

  logic [4:0]  angle_steps;
  logic [9:0]  segment_count;
  logic [1:0]  tex_mode;
  logic [15:0] scale_u;
  logic [15:0] scale_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_steps   <= 5'd8;
      segment_count <= 10'd1;
      tex_mode      <= sorstrip_pkg::TEX_WRAP;
      scale_u       <= 16'd256;
      scale_v       <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sorstrip_pkg::CFG_ANGLE_STEPS:   angle_steps   <= cfg_data[4:0];
        sorstrip_pkg::CFG_SEGMENT_COUNT: segment_count <= cfg_data[9:0];
        sorstrip_pkg::CFG_TEX_MODE:      tex_mode      <= cfg_data[1:0];
        sorstrip_pkg::CFG_SCALE_U:       scale_u       <= cfg_data;
        sorstrip_pkg::CFG_SCALE_V:       scale_v       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [4:0]     n_eff;
  logic [9:0]     segs;
  logic [DW-1:0]  den_u;
  logic [DW-1:0]  den_v;
  logic           wrap;

  assign n_eff = (angle_steps == 5'd0) ? 5'd1 :
                 (angle_steps > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : angle_steps;
  assign segs  = (segment_count == 10'd0) ? 10'd1 : segment_count;
  assign wrap  = tex_mode == sorstrip_pkg::TEX_WRAP;
  assign den_u = wrap ? DW'(n_eff) : ((scale_u == 16'd0) ? 16'd1 : scale_u);
  assign den_v = wrap ? DW'(segs) : ((scale_v == 16'd0) ? 16'd1 : scale_v);

  logic en;
  assign en = !out_valid || out_ready;

  // step sequencer
  logic              busy;
  logic [4:0]        step;
  logic              far_side;
  sorstrip_pkg::in_t seg;
  logic              final_op;

  assign final_op = far_side && (step == n_eff);
  assign in_ready = !busy || (en && final_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= 5'd0;
      far_side <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy     <= 1'b1;
      step     <= 5'd0;
      far_side <= 1'b0;
    end else if (busy && en) begin
      if (far_side) begin
        if (step == n_eff) begin
          busy <= 1'b0;
        end else begin
          step <= step + 5'd1;
        end
        far_side <= 1'b0;
      end else begin
        far_side <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg <= in_data;
    end
  end

  // stage 1: operand select and trig read
  logic               s1_valid;
  logic signed [15:0] s1_r;
  logic signed [15:0] s1_h;
  logic [4:0]         s1_i;
  logic [10:0]        s1_k;
  logic               s1_last;
  logic [31:0]        s1_trig;
  logic [4:0]         trig_i;

  assign trig_i = (step == n_eff) ? 5'd0 : step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= far_side ? seg.radius_far : seg.radius_near;
      s1_h    <= far_side ? seg.height_far : seg.height_near;
      s1_i    <= step;
      s1_k    <= 11'(seg.segment_index) + 11'(far_side);
      s1_last <= final_op;
      s1_trig <= TRIG_ROM[{n_eff, trig_i}];
    end
  end

  // stage 2: products
  logic               s2_valid;
  logic signed [31:0] s2_px;
  logic signed [31:0] s2_py;
  logic signed [15:0] s2_z;
  logic signed [15:0] s2_c;
  logic signed [15:0] s2_s;
  logic [20:0]        s2_ui;
  logic [NW-1:0]      s2_vk;
  logic               s2_last;
  logic               s2_force;
  logic [26:0]        vk_full;

  assign vk_full = 27'(scale_v) * 27'(s1_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px    <= s1_r * $signed(s1_trig[31:16]);
      s2_py    <= s1_r * $signed(s1_trig[15:0]);
      s2_z     <= s1_h;
      s2_c     <= $signed(s1_trig[31:16]);
      s2_s     <= $signed(s1_trig[15:0]);
      s2_ui    <= 21'(scale_u) * 21'(s1_i);
      s2_vk    <= vk_full[NW-1:0];
      s2_last  <= s1_last;
      s2_force <= (tex_mode == sorstrip_pkg::TEX_ONESIDED) && (s1_i <= (n_eff >> 1));
    end
  end

  // stage 3: round, saturate, form numerators
  function automatic logic signed [15:0] round_sat(logic signed [31:0] p);
    logic [31:0] mag;
    logic [17:0] m;
    mag = p[31] ? 32'(-p) : 32'(p);
    m   = 18'((mag + 32'd8192) >> 14);
    if (p[31]) round_sat = (m > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, m}));
    else round_sat = (m > 18'd32767) ? 16'sd32767 : 16'(m);
  endfunction

  function automatic logic [NW-1:0] mag_q88(logic signed [15:0] v);
    logic [16:0] m;
    m = v[15] ? 17'(-$signed({v[15], v})) : 17'({1'b0, v});
    mag_q88 = NW'({m, 8'd0});
  endfunction

  logic signed [15:0]     x3;
  logic signed [15:0]     y3;
  logic [NW-1:0]          num_u;
  logic [NW-1:0]          num_v;
  sorstrip_pkg::vtx_tag_t tag3;
  sorstrip_pkg::v_tag_t   vtag3;
  logic signed [15:0]     vsrc;

  assign x3   = round_sat(s2_px);
  assign y3   = round_sat(s2_py);
  assign vsrc = (tex_mode == sorstrip_pkg::TEX_TOP) ? y3 : s2_z;

  always_comb begin
    num_u = wrap ? NW'(s2_ui) : mag_q88(x3);
    num_v = wrap ? s2_vk : mag_q88(vsrc);
    tag3.pos_x    = x3;
    tag3.pos_y    = y3;
    tag3.pos_z    = s2_z;
    tag3.normal_x = s2_c;
    tag3.normal_y = s2_s;
    tag3.last     = s2_last;
    tag3.u_neg    = !wrap && x3[15];
    tag3.u_half   = !wrap;
    tag3.u_force  = s2_force;
    vtag3.v_neg   = !wrap && vsrc[15];
    vtag3.v_half  = tex_mode == sorstrip_pkg::TEX_TOP;
  end

  logic                   s3_valid;
  logic [NW-1:0]          s3_num_u;
  logic [NW-1:0]          s3_num_v;
  sorstrip_pkg::vtx_tag_t s3_tag;
  sorstrip_pkg::v_tag_t   s3_vtag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_u <= num_u;
      s3_num_v <= num_v;
      s3_tag   <= tag3;
      s3_vtag  <= vtag3;
    end
  end

  // dividers
  logic                   du_valid;
  logic                   dv_valid;
  logic [NW-1:0]          quo_u;
  logic [NW-1:0]          quo_v;
  logic [TAGW-1:0]        du_tag;
  logic [VTW-1:0]         dv_tag;
  sorstrip_pkg::vtx_tag_t d_tag;
  sorstrip_pkg::v_tag_t   d_vtag;

  sorstrip_div #(.W(NW), .DW(DW), .TW(TAGW)) u_div_u (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .num       (s3_num_u),
    .den       (den_u),
    .tag_in    (s3_tag),
    .out_valid (du_valid),
    .quo       (quo_u),
    .tag_out   (du_tag)
  );

  sorstrip_div #(.W(NW), .DW(DW), .TW(VTW)) u_div_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .num       (s3_num_v),
    .den       (den_v),
    .tag_in    (s3_vtag),
    .out_valid (dv_valid),
    .quo       (quo_v),
    .tag_out   (dv_tag)
  );

  assign d_tag  = du_tag;
  assign d_vtag = dv_tag;

  function automatic logic signed [15:0] finish(logic [NW-1:0] q, logic neg, logic half);
    logic signed [27:0] v;
    v = neg ? -$signed(28'(q)) : $signed(28'(q));
    if (half) v = v - sorstrip_pkg::HALF_Q88;
    if (v > 28'sd32767) finish = 16'sd32767;
    else if (v < -28'sd32768) finish = -16'sd32768;
    else finish = 16'(v);
  endfunction

  sorstrip_pkg::out_t out_next;

  always_comb begin
    out_next.pos_x    = d_tag.pos_x;
    out_next.pos_y    = d_tag.pos_y;
    out_next.pos_z    = d_tag.pos_z;
    out_next.normal_x = d_tag.normal_x;
    out_next.normal_y = d_tag.normal_y;
    out_next.tex_u    = d_tag.u_force ? sorstrip_pkg::MINUS_ONE_Q88 :
                        finish(quo_u, d_tag.u_neg, d_tag.u_half);
    out_next.tex_v    = finish(quo_v, d_vtag.v_neg, d_vtag.v_half);
    out_next.last     = d_tag.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= du_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  `SORS_CHECK(a_div_lockstep, du_valid == dv_valid)
  `SORS_CHECK(a_accept_starts, (in_valid && in_ready) |=> (busy && step == 5'd0 && !far_side))
  `SORS_CHECK(a_final_frees, (busy && en && final_op && !in_valid) |=> !busy)
  `SORS_CHECK_RST(a_reset_empty, rst |=> (!out_valid && !busy))

endmodule

### sim/surface_of_revolution_strip_unit_test.sv
// Testbench for the surface-of-revolution strip unit: directed and random segments checked vertex by vertex
`timescale 1ns / 1ps
module surface_of_revolution_strip_unit_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sorstrip_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sorstrip_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sorstrip_pkg::in_t segment_q[$];
  sorstrip_pkg::out_t vertex_q[$];
  int mismatches = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  logic quiet = 1'b0;

  logic [4:0] steps_reg = 5'd8;
  logic [9:0] segs_reg = 10'd1;
  logic [1:0] mode_reg = sorstrip_pkg::TEX_WRAP;
  logic [15:0] su_reg = 16'd256;
  logic [15:0] sv_reg = 16'd256;

  surface_of_revolution_strip_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_q14(real v);
    if (v >= 0.0) return longint'($floor(v + 0.5));
    return -longint'($floor(0.5 - v));
  endfunction

  function automatic longint rot_scale(longint r, longint t);
    longint p, mag;
    p = r * t;
    mag = (p < 0) ? -p : p;
    mag = (mag + 8192) / 16384;
    return sat16((p < 0) ? -mag : mag);
  endfunction

  function automatic longint div_scale(longint num, logic [15:0] den);
    longint d;
    d = (den == 0) ? 1 : longint'(den);
    return (num * 256) / d;
  endfunction

  function automatic void forecast_strip(sorstrip_pkg::in_t seg);
    int n, segs, j;
    longint rad[2], hgt[2];
    longint c, s, x, y, z, u, v;
    real ang;
    sorstrip_pkg::out_t o;
    n = (steps_reg == 0) ? 1 : int'(steps_reg);
    segs = (segs_reg == 0) ? 1 : int'(segs_reg);
    j = int'(seg.segment_index);
    rad[0] = longint'($signed(seg.radius_near));
    hgt[0] = longint'($signed(seg.height_near));
    rad[1] = longint'($signed(seg.radius_far));
    hgt[1] = longint'($signed(seg.height_far));
    for (int i = 0; i <= n; i++) begin
      ang = 2.0 * 3.14159265358979323846 * ((i == n) ? 0 : i) / n;
      c = round_q14($cos(ang) * 16384.0);
      s = round_q14($sin(ang) * 16384.0);
      for (int side = 0; side < 2; side++) begin
        x = rot_scale(rad[side], c);
        y = rot_scale(rad[side], s);
        z = hgt[side];
        case (mode_reg)
          sorstrip_pkg::TEX_WRAP: begin
            u = (longint'(su_reg) * i) / n;
            v = (longint'(sv_reg) * (j + side)) / segs;
          end
          sorstrip_pkg::TEX_SIDE: begin
            u = div_scale(x, su_reg) - 128;
            v = div_scale(z, sv_reg);
          end
          sorstrip_pkg::TEX_TOP: begin
            u = div_scale(x, su_reg) - 128;
            v = div_scale(y, sv_reg) - 128;
          end
          default: begin
            u = (i <= n / 2) ? -256 : div_scale(x, su_reg) - 128;
            v = div_scale(z, sv_reg);
          end
        endcase
        o.pos_x = 16'(x);
        o.pos_y = 16'(y);
        o.pos_z = 16'(z);
        o.normal_x = 16'(c);
        o.normal_y = 16'(s);
        o.tex_u = 16'(sat16(u));
        o.tex_v = 16'(sat16(v));
        o.last = (i == n && side == 1);
        vertex_q.push_back(o);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) forecast_strip(in_data);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (segment_q.size() > 0) begin
        in_data <= segment_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= quiet ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected vertex %p", out_data);
        end else if (vertex_q[0] !== out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("vertex mismatch: expected %p actual %p",
                                        vertex_q[0], out_data);
          void'(vertex_q.pop_front());
        end else begin
          void'(vertex_q.pop_front());
        end
        recv_stall = quiet ? 0 : $urandom_range(0, 10);
      end else if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
      end
      out_ready <= (recv_stall == 0) && (hold_left == 0) && !hold_start;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sorstrip_pkg::CFG_ANGLE_STEPS: steps_reg = val[4:0];
      sorstrip_pkg::CFG_SEGMENT_COUNT: segs_reg = val[9:0];
      sorstrip_pkg::CFG_TEX_MODE: mode_reg = val[1:0];
      sorstrip_pkg::CFG_SCALE_U: su_reg = val;
      default: sv_reg = val;
    endcase
  endtask

  task automatic set_all(int n, int sg, logic [1:0] m, int su, int sv);
    write_reg(sorstrip_pkg::CFG_ANGLE_STEPS, 16'(n));
    write_reg(sorstrip_pkg::CFG_SEGMENT_COUNT, 16'(sg));
    write_reg(sorstrip_pkg::CFG_TEX_MODE, 16'(m));
    write_reg(sorstrip_pkg::CFG_SCALE_U, 16'(su));
    write_reg(sorstrip_pkg::CFG_SCALE_V, 16'(sv));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (segment_q.size() > 0 || in_valid || vertex_q.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  function automatic sorstrip_pkg::in_t rand_segment();
    sorstrip_pkg::in_t it;
    it.radius_near = pick16();
    it.height_near = pick16();
    it.radius_far = pick16();
    it.height_far = pick16();
    it.segment_index = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  initial begin
    int n, m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // default registers, field extremes
    segment_q.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 10'd0});
    segment_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 10'd1023});
    segment_q.push_back('{16'sh0000, 16'sh0000, 16'shFFFF, 16'sh0001, 10'd1022});
    segment_q.push_back('{16'sh0100, 16'sh0080, 16'sh0200, 16'shFF00, 10'd0});
    wait_idle();
    for (int md = 0; md < 4; md++) begin
      set_all(4, 0, 2'(md), 0, 0);
      segment_q.push_back('{16'sh8000, 16'sh0100, 16'sh7FFF, 16'sh8000, 10'd3});
      segment_q.push_back('{16'sh0300, 16'sh7FFF, 16'shFD00, 16'sh0000, 10'd1023});
      wait_idle();
      set_all(md == 0 ? 31 : 0, 1023, 2'(md), 65535, 1);
      segment_q.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 10'd1023});
      wait_idle();
    end
    for (int ph = 0; ph < 16; ph++) begin
      n = (ph % 5 == 0) ? 31 : $urandom_range(0, 12);
      m = ph % 4;
      set_all(n, $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 40), 2'(m),
              $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 1024),
              $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 1024));
      quiet <= (ph == 3);
      for (int k = 0; k < 27; k++) segment_q.push_back(rand_segment());
      if (ph == 6) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_idle();
    end
    quiet <= 1'b0;
    set_all(8, 1, sorstrip_pkg::TEX_WRAP, 256, 256);
    for (int k = 0; k < 10; k++) segment_q.push_back(rand_segment());
    wait_idle();
    if (mismatches == 0 && vertex_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
